// ----- hw/rtl/gbts_pkg.sv -----
// Shared constants and codes for the gap buffer text store.
// Store size, field widths, operation and status codes.
// No dependencies.
package gbts_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int PTR_W        = $clog2(BUFFER_BYTES + 1);

    localparam int OP_W   = 2;
    localparam int POS_W  = 11;
    localparam int CNT_W  = 11;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 11;

    // shared adder is one bit wider than anything it compares
    localparam int ALU_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_BEYOND   = 2'd2,
        ST_PAST_END = 2'd3
    } status_t;

endpackage

// ----- hw/rtl/gap_buffer_text_store.sv -----
// Top level of the gap buffer text store: sequencer, gap pointers, stream ports.
// Depends on gbts_pkg, gbts_alu and gbts_ram.
//
// One operation per input transfer; the block is not ready until that operation's result
// has been loaded into the output register, which may still be waiting while the next
// transfer is taken. Reads, no-ops and refused operations move no bytes. An insert moves
// the gap to the position one byte at a time, then writes count fill bytes; an erase
// moves the gap the same way, then widens it over count bytes. While the sink still holds
// the result register, the sequencer waits. Gap moves and fills go through the single
// RAM write port one byte per cycle, and the checks and pointer sums are done in turn
// on one shared adder. No clearing pass is needed.
module gap_buffer_text_store import gbts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // op[1:0], position[12:2], count[23:13], fill_char[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // read_char[7:0], status[9:8], text_length[20:10], zero
);

    localparam int OUT_W = CHAR_W + STAT_W + LEN_W;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_CHK_POS  = 13'b0000000000010,
        S_CHK_A    = 13'b0000000000100,
        S_CHK_B    = 13'b0000000001000,
        S_MOVE     = 13'b0000000010000,
        S_FILL     = 13'b0000000100000,
        S_ER_STOP  = 13'b0000001000000,
        S_ER_LEN   = 13'b0000010000000,
        S_RD_SIDE  = 13'b0000100000000,
        S_RD_GAP   = 13'b0001000000000,
        S_RD_ADDR  = 13'b0010000000000,
        S_RD_DATA  = 13'b0100000000000,
        S_FIN      = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CHAR_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]    gstart_reg, gstart_next;
    logic [PTR_W-1:0]    gstop_reg, gstop_next;
    logic [PTR_W-1:0]    len_reg, len_next;
    logic [ALU_W-1:0]    tmp_reg, tmp_next;
    status_t             status_reg, status_next;
    logic [CHAR_W-1:0]   rchar_reg, rchar_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_data_reg, m_data_next;

    logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
    logic                alu_sub, alu_lt, alu_zero;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [CHAR_W-1:0]   ram_wdata, ram_rdata;

    logic [PTR_W-1:0]    gstart_inc, gstart_dec, gstop_inc, gstop_dec;
    logic                s_xfer;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_xfer        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {{(24 - OUT_W){1'b0}}, m_data_reg};

    assign gstart_inc = gstart_reg + PTR_W'(1);
    assign gstart_dec = gstart_reg - PTR_W'(1);
    assign gstop_inc  = gstop_reg + PTR_W'(1);
    assign gstop_dec  = gstop_reg - PTR_W'(1);

    gbts_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .res  (alu_res),
        .lt   (alu_lt),
        .zero (alu_zero)
    );

    gbts_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operand selection for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            S_CHK_POS: begin
                if (op_reg == OP_READ) begin
                    alu_a = ALU_W'(pos_reg);
                    alu_b = ALU_W'(len_reg);
                end else begin
                    alu_a = ALU_W'(len_reg);
                    alu_b = ALU_W'(pos_reg);
                end
            end
            S_CHK_A: begin
                if (op_reg == OP_INSERT) begin
                    alu_a = ALU_W'(gstop_reg);
                    alu_b = ALU_W'(gstart_reg);
                end else begin
                    alu_a = ALU_W'(len_reg);
                    alu_b = ALU_W'(pos_reg);
                end
            end
            S_CHK_B: begin
                alu_a = tmp_reg;
                alu_b = ALU_W'(cnt_reg);
            end
            S_MOVE, S_RD_SIDE: begin
                alu_a = (state_reg == S_MOVE) ? ALU_W'(gstart_reg) : ALU_W'(pos_reg);
                alu_b = (state_reg == S_MOVE) ? ALU_W'(pos_reg) : ALU_W'(gstart_reg);
            end
            S_ER_STOP: begin
                alu_a   = ALU_W'(gstop_reg);
                alu_b   = ALU_W'(cnt_reg);
                alu_sub = 1'b0;
            end
            S_ER_LEN: begin
                alu_a = ALU_W'(len_reg);
                alu_b = ALU_W'(cnt_reg);
            end
            S_RD_GAP: begin
                alu_a = ALU_W'(gstop_reg);
                alu_b = ALU_W'(gstart_reg);
            end
            S_RD_ADDR: begin
                alu_a   = ALU_W'(pos_reg);
                alu_b   = tmp_reg;
                alu_sub = 1'b0;
            end
            S_IDLE, S_FILL, S_RD_DATA, S_FIN: begin
                alu_a = '0;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        gstart_next    = gstart_reg;
        gstop_next     = gstop_reg;
        len_next       = len_reg;
        tmp_next       = tmp_reg;
        status_next    = status_reg;
        rchar_next     = rchar_reg;
        pend_vld_next  = pend_vld_reg;
        pend_addr_next = pend_addr_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_axis_tready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    op_next     = op_t'(s_axis_tdata[1:0]);
                    pos_next    = s_axis_tdata[12:2];
                    cnt_next    = s_axis_tdata[23:13];
                    fill_next   = s_axis_tdata[31:24];
                    status_next = ST_OK;
                    rchar_next  = '0;
                    state_next  = S_CHK_POS;
                end
            end
            S_CHK_POS: begin
                if (op_reg == OP_NOP) begin
                    state_next = S_FIN;
                end else if (op_reg == OP_READ) begin
                    if (!alu_lt) begin
                        status_next = ST_BEYOND;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_RD_SIDE;
                    end
                end else if (alu_lt) begin
                    status_next = ST_BEYOND;
                    state_next  = S_FIN;
                end else begin
                    state_next = S_CHK_A;
                end
            end
            S_CHK_A: begin
                // gap size for insert, bytes after position for erase
                tmp_next   = alu_res;
                state_next = S_CHK_B;
            end
            S_CHK_B: begin
                if (alu_lt) begin
                    status_next = (op_reg == OP_INSERT) ? ST_NO_ROOM : ST_PAST_END;
                    state_next  = S_FIN;
                end else begin
                    pend_vld_next = 1'b0;
                    state_next    = S_MOVE;
                end
            end
            S_MOVE: begin
                // read issued last cycle lands now; write it to its new slot
                ram_we = pend_vld_reg;
                if (alu_zero) begin
                    pend_vld_next = 1'b0;
                    state_next    = (op_reg == OP_INSERT) ? S_FILL : S_ER_STOP;
                end else if (alu_lt) begin
                    ram_raddr      = ADDR_W'(gstop_reg);
                    pend_addr_next = ADDR_W'(gstart_reg);
                    pend_vld_next  = 1'b1;
                    gstart_next    = gstart_inc;
                    gstop_next     = gstop_inc;
                end else begin
                    ram_raddr      = ADDR_W'(gstart_dec);
                    pend_addr_next = ADDR_W'(gstop_dec);
                    pend_vld_next  = 1'b1;
                    gstart_next    = gstart_dec;
                    gstop_next     = gstop_dec;
                end
            end
            S_FILL: begin
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    ram_we      = 1'b1;
                    ram_waddr   = ADDR_W'(gstart_reg);
                    ram_wdata   = fill_reg;
                    gstart_next = gstart_inc;
                    len_next    = len_reg + PTR_W'(1);
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
            S_ER_STOP: begin
                gstop_next = PTR_W'(alu_res);
                state_next = S_ER_LEN;
            end
            S_ER_LEN: begin
                len_next   = PTR_W'(alu_res);
                state_next = S_FIN;
            end
            S_RD_SIDE: begin
                if (alu_lt) begin
                    ram_raddr  = ADDR_W'(pos_reg);
                    state_next = S_RD_DATA;
                end else begin
                    state_next = S_RD_GAP;
                end
            end
            S_RD_GAP: begin
                tmp_next   = alu_res;
                state_next = S_RD_ADDR;
            end
            S_RD_ADDR: begin
                ram_raddr  = ADDR_W'(alu_res);
                state_next = S_RD_DATA;
            end
            S_RD_DATA: begin
                rchar_next = ram_rdata;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {LEN_W'(len_reg), status_reg, rchar_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            gstart_reg   <= '0;
            gstop_reg    <= PTR_W'(BUFFER_BYTES);
            len_reg      <= '0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gstart_reg   <= gstart_next;
            gstop_reg    <= gstop_next;
            len_reg      <= len_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        fill_reg      <= fill_next;
        tmp_reg       <= tmp_next;
        status_reg    <= status_next;
        rchar_reg     <= rchar_next;
        pend_addr_reg <= pend_addr_next;
        m_data_reg    <= m_data_next;
    end

endmodule

// ----- hw/rtl/gbts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the text bytes of the gap buffer.
// No package dependency.
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/gbts_alu.sv -----
// Shared add / subtract-compare unit of the gap buffer sequencer.
// Depends on gbts_pkg for the operand width.
module gbts_alu import gbts_pkg::*; (
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  logic             sub,
    output logic [ALU_W-1:0] res,
    output logic             lt,
    output logic             zero
);

    logic [ALU_W:0] sum;

    // a - b as a + ~b + 1; missing carry out means a < b
    always_comb begin
        sum  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
        res  = sum[ALU_W-1:0];
        lt   = sub & ~sum[ALU_W];
        zero = (sum[ALU_W-1:0] == '0);
    end

endmodule
